@@ design/hc_pkg.sv @@
// Shared types, constants and modulo-26 helpers for the 2x2 Hill cipher unit.
package hc_pkg;

  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned MODULUS   = 26;
  // floor(x / 26) == (x * RECIP_26) >> 16 for every x below 2048
  localparam int unsigned RECIP_26  = 2521;
  // settle count loaded on each register write; the derived matrix is valid once it runs out
  localparam int unsigned KEY_LATENCY = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE  = 3'd0,
    REG_KEY_ROW0_COL0 = 3'd1,
    REG_KEY_ROW0_COL1 = 3'd2,
    REG_KEY_ROW1_COL0 = 3'd3,
    REG_KEY_ROW1_COL1 = 3'd4
  } cfg_reg_t;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    letter_t letter_in;
    logic    last_letter;
  } in_item_t;

  typedef struct packed {
    letter_t letter_out;
    logic    last_out;
    logic    key_singular;
  } out_item_t;

  // one complete pair handed from the front end to the back end
  typedef struct packed {
    letter_t x0;
    letter_t x1;
    logic    last;
  } pair_t;

  // matrix in force plus its status
  typedef struct packed {
    letter_t m0;
    letter_t m1;
    letter_t m2;
    letter_t m3;
    logic    singular;
    logic    ready;
  } key_t;

  // reduce a 5-bit value that may be 26..31
  function automatic letter_t red26(input letter_t v);
    letter_t r;
    r = (v >= LETTER_W'(MODULUS)) ? v - LETTER_W'(MODULUS) : v;
    return r;
  endfunction

  // x mod 26 for x below 2048, by reciprocal multiply and one correction
  function automatic letter_t mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 23'(x) * 23'(RECIP_26);
    q    = prod[22:16];
    r    = x - 11'(11'(q) * 11'(MODULUS));
    if (r >= 11'(MODULUS)) begin
      r = r - 11'(MODULUS);
    end
    return r[LETTER_W-1:0];
  endfunction

  // (26 - r) mod 26 for r in 0..25
  function automatic letter_t neg26(input letter_t r);
    letter_t n;
    n = (r == '0) ? '0 : LETTER_W'(MODULUS) - r;
    return n;
  endfunction

  // multiplicative inverse mod 26, zero where none exists
  function automatic letter_t inv26(input letter_t d);
    letter_t v;
    unique case (d)
      5'd1:    v = 5'd1;
      5'd3:    v = 5'd9;
      5'd5:    v = 5'd21;
      5'd7:    v = 5'd15;
      5'd9:    v = 5'd3;
      5'd11:   v = 5'd19;
      5'd15:   v = 5'd7;
      5'd17:   v = 5'd23;
      5'd19:   v = 5'd11;
      5'd21:   v = 5'd5;
      5'd23:   v = 5'd17;
      5'd25:   v = 5'd25;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/hill_cipher_2x2_mod26_unit.sv @@
// Hill cipher 2x2 mod 26 unit: top level joining front end, queue, key schedule, back end.
// Letters (0..25; 26..31 act as their value mod 26) enter one request per cycle on the
// input channel while the queue is not full. The first letter of each pair is held; the
// second completes the pair, which is multiplied by the key matrix (encrypt) or by its
// inverse mod 26 (decrypt) and leaves as two result requests, first row first. A message
// that ends on an odd letter is padded with letter 0 and still yields both letters,
// last_out marking the second. Sustained rate is one letter in and one letter out per
// cycle while neither side stalls: a pair leaves as two letters and arrives as two. From
// the second letter of a pair to its first result the pair passes the queue, the product
// stage and the output register. A queue of QUEUE_DEPTH pairs lets the input keep flowing
// while the output is stalled. Register writes take effect after a five-stage key schedule
// pipeline (reduce and determinant products, mod 26, inverse lookup, scaling, final
// matrix); pairs wait in the queue until it has settled after the last write and after
// reset. With a singular key in decrypt mode both letters are 0 and key_singular is set.
module hill_cipher_2x2_mod26_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hc_pkg::in_item_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hc_pkg::out_item_t             out_data,
  input  logic                          cfg_write,
  input  logic [hc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  hc_pkg::pair_t q_in;
  hc_pkg::pair_t q_out;
  hc_pkg::key_t  key;

  // classify letters and build pairs
  hc_fe u_fe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  // decouple the input side from output stalls
  hc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // hold the registers and derive the matrix in force
  hc_ksch u_ksch (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // transform pairs and serialize the two letters
  hc_be u_be (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .q_empty   (q_empty),
    .pop_data  (q_out),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/hc_queue.sv @@
// Small FIFO of letter pairs between the front end and the back end.
module hc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hc_pkg::pair_t push_data,
  input  logic          pop,
  output hc_pkg::pair_t pop_data,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hc_pkg::pair_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/hc_fe.sv @@
// Front end: take letters, hold the first of each pair, queue complete pairs.
module hc_fe (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hc_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             push,
  output hc_pkg::pair_t    push_data
);

  hc_pkg::letter_t held_letter;
  logic            holding_first;
  hc_pkg::letter_t letter;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign letter   = hc_pkg::red26(in_data.letter_in);

  // a pair is complete on the second letter, or on a lone last letter (pad 0)
  assign push = accept && (holding_first || in_data.last_letter);

  always_comb begin
    if (holding_first) begin
      push_data.x0   = held_letter;
      push_data.x1   = letter;
      push_data.last = in_data.last_letter;
    end else begin
      push_data.x0   = letter;
      push_data.x1   = '0;
      push_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding_first <= 1'b0;
      held_letter   <= '0;
    end else if (accept) begin
      if (holding_first) begin
        holding_first <= 1'b0;
      end else if (!in_data.last_letter) begin
        holding_first <= 1'b1;
        held_letter   <= letter;
      end
    end
  end

endmodule

@@ design/hc_ksch.sv @@
// Key schedule: configuration registers and the pipelined matrix derivation.
module hc_ksch (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [hc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hc_pkg::key_t                    key
);

  logic            decrypt_mode;
  hc_pkg::letter_t key_row0_col0;
  hc_pkg::letter_t key_row0_col1;
  hc_pkg::letter_t key_row1_col0;
  hc_pkg::letter_t key_row1_col1;
  logic [2:0]      settle;

  // stage 1: reduced entries and determinant products
  logic            mode1;
  hc_pkg::letter_t a1, b1, c1, d1;
  logic [9:0]      ad1, bc1;
  // stage 2: products mod 26
  logic            mode2;
  hc_pkg::letter_t a2, b2, c2, d2;
  hc_pkg::letter_t adm2, bcm2;
  // stage 3: inverse determinant
  logic            mode3;
  hc_pkg::letter_t a3, b3, c3, d3;
  hc_pkg::letter_t inv3;
  // stage 4: entries scaled by the inverse
  logic            mode4;
  logic            sing4;
  hc_pkg::letter_t a4, b4, c4, d4;
  logic [9:0]      pa4, pb4, pc4, pd4;
  // stage 5: matrix in force
  hc_pkg::letter_t m0, m1, m2, m3;
  logic            singular;

  hc_pkg::letter_t ar, br, cr, dr;
  logic [5:0]      det_wide;
  hc_pkg::letter_t det;

  assign ar = hc_pkg::red26(key_row0_col0);
  assign br = hc_pkg::red26(key_row0_col1);
  assign cr = hc_pkg::red26(key_row1_col0);
  assign dr = hc_pkg::red26(key_row1_col1);

  assign det_wide = (adm2 >= bcm2) ? 6'(adm2) - 6'(bcm2)
                                   : 6'(adm2) + 6'(hc_pkg::MODULUS) - 6'(bcm2);
  assign det      = det_wide[hc_pkg::LETTER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode  <= 1'b0;
      key_row0_col0 <= 5'd9;
      key_row0_col1 <= 5'd4;
      key_row1_col0 <= 5'd5;
      key_row1_col1 <= 5'd7;
      settle        <= 3'(hc_pkg::KEY_LATENCY);
    end else begin
      if (cfg_write) begin
        settle <= 3'(hc_pkg::KEY_LATENCY);
        unique case (cfg_index)
          hc_pkg::REG_DECRYPT_MODE:  decrypt_mode  <= cfg_data[0];
          hc_pkg::REG_KEY_ROW0_COL0: key_row0_col0 <= cfg_data;
          hc_pkg::REG_KEY_ROW0_COL1: key_row0_col1 <= cfg_data;
          hc_pkg::REG_KEY_ROW1_COL0: key_row1_col0 <= cfg_data;
          hc_pkg::REG_KEY_ROW1_COL1: key_row1_col1 <= cfg_data;
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode1 <= decrypt_mode;
    a1 <= ar; b1 <= br; c1 <= cr; d1 <= dr;
    ad1 <= 10'(ar) * 10'(dr);
    bc1 <= 10'(br) * 10'(cr);

    mode2 <= mode1;
    a2 <= a1; b2 <= b1; c2 <= c1; d2 <= d1;
    adm2 <= hc_pkg::mod26(11'(ad1));
    bcm2 <= hc_pkg::mod26(11'(bc1));

    mode3 <= mode2;
    a3 <= a2; b3 <= b2; c3 <= c2; d3 <= d2;
    inv3 <= hc_pkg::inv26(det);

    mode4 <= mode3;
    sing4 <= (inv3 == '0);
    a4 <= a3; b4 <= b3; c4 <= c3; d4 <= d3;
    pa4 <= 10'(a3) * 10'(inv3);
    pb4 <= 10'(b3) * 10'(inv3);
    pc4 <= 10'(c3) * 10'(inv3);
    pd4 <= 10'(d3) * 10'(inv3);

    if (mode4) begin
      m0       <= hc_pkg::mod26(11'(pd4));
      m1       <= hc_pkg::neg26(hc_pkg::mod26(11'(pb4)));
      m2       <= hc_pkg::neg26(hc_pkg::mod26(11'(pc4)));
      m3       <= hc_pkg::mod26(11'(pa4));
      singular <= sing4;
    end else begin
      m0       <= a4;
      m1       <= b4;
      m2       <= c4;
      m3       <= d4;
      singular <= 1'b0;
    end
  end

  assign key.m0       = m0;
  assign key.m1       = m1;
  assign key.m2       = m2;
  assign key.m3       = m3;
  assign key.singular = singular;
  assign key.ready    = (settle == '0);

endmodule

@@ design/hc_be.sv @@
// Back end: pair times matrix, reduce mod 26, send the two letters in order.
module hc_be (
  input  logic              clk,
  input  logic              rst,
  input  hc_pkg::key_t      key,
  input  logic              q_empty,
  input  hc_pkg::pair_t     pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output hc_pkg::out_item_t out_data
);

  // product stage
  logic            s1_valid;
  logic [10:0]     y0_raw, y1_raw;
  logic            s1_last;
  logic            s1_sing;
  // output pair register
  logic            ser_valid;
  logic            ser_second;
  hc_pkg::letter_t y0, y1;
  logic            ser_last;
  logic            ser_sing;

  logic            ser_load_ok;
  logic            s1_advance;

  assign ser_load_ok = !ser_valid || (ser_second && out_ready);
  assign s1_advance  = !s1_valid || ser_load_ok;
  assign pop         = !q_empty && key.ready && s1_advance;

  assign out_valid             = ser_valid;
  assign out_data.letter_out   = ser_second ? y1 : y0;
  assign out_data.last_out     = ser_second && ser_last;
  assign out_data.key_singular = ser_sing;

  always_ff @(posedge clk) begin
    if (pop) begin
      y0_raw  <= 11'(key.m0) * 11'(pop_data.x0) + 11'(key.m1) * 11'(pop_data.x1);
      y1_raw  <= 11'(key.m2) * 11'(pop_data.x0) + 11'(key.m3) * 11'(pop_data.x1);
      s1_last <= pop_data.last;
      s1_sing <= key.singular;
    end
    if (ser_load_ok && s1_valid) begin
      y0       <= hc_pkg::mod26(y0_raw);
      y1       <= hc_pkg::mod26(y1_raw);
      ser_last <= s1_last;
      ser_sing <= s1_sing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      ser_valid  <= 1'b0;
      ser_second <= 1'b0;
    end else begin
      if (s1_advance) begin
        s1_valid <= pop;
      end
      if (ser_load_ok) begin
        ser_valid  <= s1_valid;
        ser_second <= 1'b0;
      end else if (out_ready) begin
        // first letter taken, advance to the second
        ser_second <= 1'b1;
      end
    end
  end

endmodule

@@ design/hc_checker.sv @@
// Port-level checker for the Hill cipher unit and its bind to the top level.
module hc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input hc_pkg::out_item_t out_data
);

  // a stalled result holds its letter
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a singular key always produces letter 0
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_singular |-> out_data.letter_out == '0)
    else $error("singular key gave a nonzero letter");

  // every result letter is a reduced index
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.letter_out < 5'd26)
    else $error("result letter out of range");

  // reset empties the output side
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind hill_cipher_2x2_mod26_unit hc_checker u_hc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/sv/hc_tb_pkg.sv @@
// Scoreboard for the 2x2 Hill cipher unit: pair predictor and queue of expected letters.
`timescale 1ns / 100ps
package hc_tb_pkg;
  import hc_pkg::*;

  // first register index that the unit does not implement
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = 3'd5;

  class cipher_scoreboard;
    bit          decrypt;
    letter_t     key_entry[4];
    letter_t     held;
    bit          holding;
    out_item_t   expected_letters[$];
    int unsigned mismatches;

    function new();
      decrypt   = 1'b0;
      key_entry = '{5'd9, 5'd4, 5'd5, 5'd7};
      held      = '0;
      holding   = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_letters.size();
    endfunction

    // mirror a register write; unknown indexes drop silently
    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_DECRYPT_MODE:  decrypt = value[0];
        REG_KEY_ROW0_COL0: key_entry[0] = value;
        REG_KEY_ROW0_COL1: key_entry[1] = value;
        REG_KEY_ROW1_COL0: key_entry[2] = value;
        REG_KEY_ROW1_COL1: key_entry[3] = value;
        default: ;
      endcase
    endfunction

    // multiply the pair by the key or its inverse mod 26 and queue both letters
    function void encipher_pair(input letter_t x0, input letter_t x1, input bit last);
      int unsigned a, b, c, d, det, inv, k;
      int unsigned m0, m1, m2, m3, y0, y1;
      bit          singular;
      a = key_entry[0] % MODULUS;
      b = key_entry[1] % MODULUS;
      c = key_entry[2] % MODULUS;
      d = key_entry[3] % MODULUS;
      singular = 1'b0;
      if (!decrypt) begin
        m0 = a; m1 = b; m2 = c; m3 = d;
      end else begin
        det = (a * d + MODULUS * MODULUS - b * c) % MODULUS;
        inv = 0;
        for (k = 1; k < MODULUS; k++) begin
          if (inv == 0 && (det * k) % MODULUS == 1) inv = k;
        end
        m0 = (d * inv) % MODULUS;
        m1 = (MODULUS - (b * inv) % MODULUS) % MODULUS;
        m2 = (MODULUS - (c * inv) % MODULUS) % MODULUS;
        m3 = (a * inv) % MODULUS;
        singular = (inv == 0);
      end
      y0 = (m0 * x0 + m1 * x1) % MODULUS;
      y1 = (m2 * x0 + m3 * x1) % MODULUS;
      expected_letters.push_back('{letter_out: letter_t'(y0), last_out: 1'b0,
                                   key_singular: singular});
      expected_letters.push_back('{letter_out: letter_t'(y1), last_out: last,
                                   key_singular: singular});
    endfunction

    // note an accepted input request
    function void accept_letter(input in_item_t it);
      if (holding) begin
        holding = 1'b0;
        encipher_pair(held, it.letter_in, it.last_letter);
      end else if (it.last_letter) begin
        encipher_pair(it.letter_in, '0, 1'b1);
      end else begin
        held    = it.letter_in;
        holding = 1'b1;
      end
    endfunction

    function void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare an accepted result request with the oldest expected letter
    function void check_letter(input out_item_t got);
      out_item_t want;
      if (expected_letters.size() == 0) begin
        note_mismatch($sformatf("unexpected result letter=%0d last=%0b singular=%0b",
                                got.letter_out, got.last_out, got.key_singular));
        return;
      end
      want = expected_letters.pop_front();
      if (got.letter_out !== want.letter_out || got.last_out !== want.last_out ||
          got.key_singular !== want.key_singular) begin
        note_mismatch($sformatf(
          "expected letter=%0d last=%0b singular=%0b, got letter=%0d last=%0b singular=%0b",
          want.letter_out, want.last_out, want.key_singular,
          got.letter_out, got.last_out, got.key_singular));
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top-level testbench for the 2x2 Hill cipher unit: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps
module tb_top;
  import hc_pkg::*;
  import hc_tb_pkg::*;

  // watchdog limit on the run length, well above a correct run
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_LETTERS = 700;
  // cycles to let the unit settle before a register write: result path plus margin
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cipher_scoreboard sb;
  int unsigned      cycle_count = 0;
  // when set, the side runs without idle cycles
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;

  hill_cipher_2x2_mod26_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[hill_cipher_2x2_mod26_unit] ERROR");
      $finish;
    end
  end

  // Monitor: sample both channels at the edge, before any NBA of this step lands.
  // A pair's result never leaves in the cycle its second letter enters, so the
  // order of the two calls does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.accept_letter(in_data);
      if (out_valid && out_ready) sb.check_letter(out_data);
    end
  end

  // Result side: draw a stall per result request, then hold ready until it goes.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one letter after a random gap; keep valid up across back-to-back requests.
  task automatic send_letter(input letter_t l, input logic last);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{letter_in: l, last_letter: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every expected letter has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Bring the unit to rest before touching its registers.
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; consecutive calls keep the write enable up.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Close a burst of writes and let the key schedule settle.
  task automatic end_writes();
    cfg_write <= 1'b0;
    repeat (KEY_LATENCY + 2) @(posedge clk);
  endtask

  // Key entries lean on the extremes, including values past 25.
  function automatic logic [CFG_DATA_W-1:0] draw_key();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd25;
      2: return 5'd31;
      default: return CFG_DATA_W'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    int unsigned sent, n, r;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset key, encrypt. Extremes, out-of-range letters, padded odd
    // message, alternating bit patterns, then leave a first letter held.
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd31, 1'b1);
    send_letter(5'd25, 1'b1);
    send_letter(5'd21, 1'b0);
    send_letter(5'd10, 1'b0);
    send_letter(5'd5, 1'b0);

    // Switch to decrypt while a letter is held; the pair uses the new mode.
    quiesce();
    write_reg(REG_DECRYPT_MODE, 5'd1);
    end_writes();
    send_letter(5'd17, 1'b1);
    send_letter(5'd3, 1'b0);
    send_letter(5'd26, 1'b1);

    // Singular key in decrypt mode: both letters zero, singular flag up.
    quiesce();
    write_reg(REG_KEY_ROW0_COL0, 5'd2);
    write_reg(REG_KEY_ROW0_COL1, 5'd4);
    write_reg(REG_KEY_ROW1_COL0, 5'd1);
    write_reg(REG_KEY_ROW1_COL1, 5'd2);
    end_writes();
    send_letter(5'd7, 1'b0);
    send_letter(5'd12, 1'b1);
    send_letter(5'd30, 1'b1);

    // Out-of-range key entries, mode bit taken from bit 0 only, unused index.
    quiesce();
    write_reg(REG_KEY_ROW0_COL0, 5'd31);
    write_reg(REG_KEY_ROW0_COL1, 5'd0);
    write_reg(REG_KEY_ROW1_COL0, 5'd26);
    write_reg(REG_KEY_ROW1_COL1, 5'd25);
    write_reg(REG_DECRYPT_MODE, 5'd30);
    write_reg(FIRST_UNUSED_REG, 5'd31);
    end_writes();
    send_letter(5'd31, 1'b0);
    send_letter(5'd0, 1'b1);
    send_letter(5'd13, 1'b1);

    // Same key, decrypt via an odd mode value.
    quiesce();
    write_reg(REG_DECRYPT_MODE, 5'd31);
    end_writes();
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b1);

    // Random phases: fresh settings each phase, messages of random length.
    sent = 0;
    while (sent < RANDOM_LETTERS) begin
      quiesce();
      for (r = REG_DECRYPT_MODE; r <= REG_KEY_ROW1_COL1; r++) begin
        if ($urandom_range(0, 1) == 1) begin
          if (r == REG_DECRYPT_MODE) write_reg(REG_DECRYPT_MODE, CFG_DATA_W'($urandom_range(0, 31)));
          else write_reg(CFG_IDX_W'(r), draw_key());
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom_range(0, 31)));
      end
      end_writes();
      in_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_letter(letter_t'($urandom_range(0, 31)), ($urandom_range(0, 5) == 0));
        sent++;
        // now and then pause mid-phase until the result side catches up
        if ($urandom_range(0, 79) == 0) drain();
      end
    end

    // Wait out every expected letter, then linger for stray results.
    drain();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[hill_cipher_2x2_mod26_unit] OK");
    end else begin
      $display("[hill_cipher_2x2_mod26_unit] ERROR");
    end
    $finish;
  end

endmodule
